// File: hw/rtl/md5bsh_pkg.sv
// md5bsh_pkg: item types and md5 constants for the byte stream hasher
// no dependencies; imported by the top level, the port checker and the testbench

package md5bsh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] valid_bits;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        error;
    } t_out_item;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] MARK_BYTE = 8'h80;
    localparam logic [3:0] FULL_BITS = 4'd8;
    localparam logic [1:0] LAST_INDEX = 2'd3;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // rotate amount depends on the round group and the low two round bits
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        return ROT_AMT[{rnd[5:4], rnd[1:0]}];
    endfunction

    // message word used by a round
    function automatic logic [3:0] word_sel(input logic [5:0] rnd);
        logic [3:0] sel;
        unique case (rnd[5:4])
            2'd0:    sel = rnd[3:0];
            2'd1:    sel = 4'(rnd[3:0] * 4'd5 + 4'd1);
            2'd2:    sel = 4'(rnd[3:0] * 4'd3 + 4'd5);
            default: sel = 4'(rnd[3:0] * 4'd7);
        endcase
        return sel;
    endfunction

endpackage

// File: hw/rtl/md5_byte_stream_hasher_top.sv
// md5 byte stream hasher: block buffer memory, round sequencer, padding and digest output
// depends on md5bsh_pkg
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+------------------------------
//  in      | in  | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | out | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// a byte item is taken every cycle while the buffer fills; the 64th byte of a block
// starts a compression (read preload, 64 rounds on one shared round unit
// fed by the 16x32 buffer memory, chain add) during which o_in_stall is high.
// a clean final item pads one byte a cycle to the block end and runs one or two compressions;
// an errored one skips both; then the four digest words go out on consecutive accepted cycles.
// reset is synchronous and needs no clearing pass; the out channel may stall at any time.

module md5_byte_stream_hasher_top
    import md5bsh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {S_RUN, S_COMP, S_FIN, S_PAD, S_OUT} t_state;

    t_state      r_state;
    logic [31:0] r_chain [4];
    logic [63:0] r_bits;
    logic        r_err;
    logic        r_padding;
    logic        r_pend_two;
    logic [7:0]  r_pend_data;
    logic [7:0]  r_mark;
    logic        r_mark_done;
    logic        r_len_ok;
    logic [5:0]  r_pad_idx;
    logic [63:0] r_total;
    logic [6:0]  r_rnd;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [1:0]  r_oidx;

    // block buffer, little-endian bytes within each message word
    logic [31:0] r_mem [16];
    logic [31:0] r_rd_word;

    logic        in_acc, out_acc, clr;
    logic        full, over;
    logic [5:0]  app_idx;
    logic [2:0]  nshort;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte, fill_byte;
    logic [3:0]  rd_addr;
    logic [5:0]  ri;
    logic [31:0] f, t;
    logic [63:0] t_dbl;

    assign o_in_stall = (r_state != S_RUN);
    assign in_acc     = i_in_valid && (r_state == S_RUN);
    assign out_acc    = o_out_valid && !i_out_stall;
    assign clr        = out_acc && (r_oidx == LAST_INDEX);

    assign full    = (i_in_item.valid_bits == FULL_BITS);
    assign over    = (i_in_item.valid_bits > FULL_BITS);
    assign nshort  = i_in_item.valid_bits[2:0];
    assign app_idx = r_bits[8:3];

    always_comb begin
        if (r_pend_two) begin
            fill_byte = r_pend_data;
        end else if (!r_mark_done) begin
            fill_byte = r_mark;
        end else if (r_len_ok && (r_pad_idx[5:3] == 3'd7)) begin
            fill_byte = r_total[{r_pad_idx[2:0], 3'b000} +: 8];
        end else begin
            fill_byte = 8'h00;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pad_idx;
        wr_byte = fill_byte;
        if (r_state == S_PAD) begin
            wr_en = 1'b1;
        end else if (in_acc && !i_in_item.end_of_message && !r_err && full) begin
            wr_en   = 1'b1;
            wr_addr = app_idx;
            wr_byte = i_in_item.data_byte;
        end
    end

    // read for round r_rnd is issued in the cycle before its use
    assign rd_addr = word_sel(r_rnd[5:0]);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
        end
        r_rd_word <= r_mem[rd_addr];
    end

    // one md5 round
    assign ri = 6'(r_rnd[5:0] - 6'd1);

    always_comb begin
        unique case (ri[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign t     = r_a + f + r_rd_word + ROUND_K[ri];
    assign t_dbl = {t, t} << rot_amount(ri);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_state     <= S_RUN;
            r_chain[0]  <= INIT_A;
            r_chain[1]  <= INIT_B;
            r_chain[2]  <= INIT_C;
            r_chain[3]  <= INIT_D;
            r_bits      <= '0;
            r_err       <= 1'b0;
            r_padding   <= 1'b0;
            r_pend_two  <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_ok    <= 1'b0;
            r_rnd       <= '0;
            r_oidx      <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    if (in_acc) begin
                        if (!i_in_item.end_of_message) begin
                            if (!r_err) begin
                                if (full) begin
                                    r_bits <= r_bits + 64'd8;
                                    if (app_idx == 6'd63) begin
                                        r_rnd   <= '0;
                                        r_state <= S_COMP;
                                    end
                                end else begin
                                    r_err <= 1'b1;
                                end
                            end
                        end else if (r_err || over) begin
                            r_err   <= 1'b1;
                            r_oidx  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_padding   <= 1'b1;
                            r_pad_idx   <= app_idx;
                            r_pend_two  <= full;
                            r_pend_data <= i_in_item.data_byte;
                            r_mark      <= full ? MARK_BYTE :
                                ((i_in_item.data_byte & ~(8'hff >> nshort))
                                 | (MARK_BYTE >> nshort));
                            r_mark_done <= 1'b0;
                            r_len_ok    <= 1'b0;
                            r_total     <= r_bits + {60'd0, i_in_item.valid_bits};
                            r_state     <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_pend_two) begin
                        r_pend_two <= 1'b0;
                    end else if (!r_mark_done) begin
                        r_mark_done <= 1'b1;
                        // length fits behind the mark only if the mark lands before byte 56
                        r_len_ok    <= (r_pad_idx[5:3] != 3'd7);
                    end
                    r_pad_idx <= 6'(r_pad_idx + 6'd1);
                    if (r_pad_idx == 6'd63) begin
                        r_rnd   <= '0;
                        r_state <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (r_rnd == 7'd0) begin
                        r_a <= r_chain[0];
                        r_b <= r_chain[1];
                        r_c <= r_chain[2];
                        r_d <= r_chain[3];
                    end else begin
                        r_a <= r_d;
                        r_d <= r_c;
                        r_c <= r_b;
                        r_b <= r_b + t_dbl[63:32];
                    end
                    r_rnd <= 7'(r_rnd + 7'd1);
                    if (r_rnd == 7'd64) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    if (!r_padding) begin
                        r_state <= S_RUN;
                    end else if (r_len_ok) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // extra block: length goes at its end once the mark is out
                        r_len_ok <= r_mark_done;
                        r_state  <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_oidx <= 2'(r_oidx + 2'd1);
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    assign o_out_valid            = (r_state == S_OUT);
    assign o_out_item.digest_word = r_err ? 32'd0 : r_chain[r_oidx];
    assign o_out_item.word_index  = r_oidx;
    assign o_out_item.last_word   = (r_oidx == LAST_INDEX);
    assign o_out_item.error       = r_err;

endmodule

// File: hw/rtl/md5bsh_checker.sv
// md5bsh_checker: port-level checks on the digest output sequence
// depends on md5bsh_pkg; bound to md5_byte_stream_hasher_top

module md5bsh_checker
    import md5bsh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    logic out_acc;
    assign out_acc = i_out_valid && !i_out_stall;

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("stalled output item changed");

    // digest words leave in order, one after another
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_out_item.last_word |=>
            i_out_valid && (i_out_item.word_index == 2'($past(i_out_item.word_index) + 2'd1)))
        else $error("digest word out of sequence");

    // the last word is word three and ends the digest
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && i_out_item.last_word |-> i_out_item.word_index == LAST_INDEX ##1 !i_out_valid)
        else $error("last word misplaced");

    // error digest carries zero words
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.error |-> i_out_item.digest_word == 32'd0)
        else $error("error digest not zero");

    // no input item is taken while the digest is out
    a_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("input taken during digest output");

endmodule

bind md5_byte_stream_hasher_top md5bsh_checker u_md5bsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for md5_byte_stream_hasher_top, message bytes in, digest words out
// holds its own md5 model of the block; depends on md5bsh_pkg and the top level rtl

module tb_top;
    import md5bsh_pkg::*;

    typedef struct {
        t_in_item item;
        bit       wait_digests;
    } t_feed;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 300;
    localparam int TAIL_ITEMS    = 40;
    localparam int RANDOM_ITEMS  = 370;
    localparam int IN_W          = $bits(t_in_item);

    // floor(abs(sin(i + 1)) * 2^32)
    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_BY_GROUP [4][4] = '{
        '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // md5 model state
    logic [31:0] md5_chain [4];
    logic [7:0]  md5_block [64];
    logic [63:0] msg_bits;
    bit          msg_corrupt;

    t_out_item digest_due [$];
    t_feed     feed [$];
    int        n_fail      = 0;
    int        cycle_count = 0;
    bit        tail_phase  = 1'b0;
    int        in_gap      = 0;
    int        in_run      = 0;
    int        out_gap     = 0;
    int        out_run     = 0;

    md5_byte_stream_hasher_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic int burst_free_span();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(0, 12);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_fail++;
    endtask

    task automatic md5_restart();
        md5_chain[0] = INIT_A;
        md5_chain[1] = INIT_B;
        md5_chain[2] = INIT_C;
        md5_chain[3] = INIT_D;
        msg_bits     = '0;
        msg_corrupt  = 1'b0;
    endtask

    task automatic md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int j, g;
        for (j = 0; j < 16; j++)
            w[j] = {md5_block[4*j+3], md5_block[4*j+2], md5_block[4*j+1], md5_block[4*j]};
        a = md5_chain[0];
        b = md5_chain[1];
        c = md5_chain[2];
        d = md5_chain[3];
        for (j = 0; j < 64; j++) begin
            case (j / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = j;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * j + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * j + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * j) % 16;
                end
            endcase
            t = a + f + w[g] + SINE_K[j];
            a = d;
            d = c;
            c = b;
            b = b + rotl32(t, ROT_BY_GROUP[j / 16][j % 4]);
        end
        md5_chain[0] += a;
        md5_chain[1] += b;
        md5_chain[2] += c;
        md5_chain[3] += d;
    endtask

    task automatic md5_absorb(input logic [7:0] v);
        int idx;
        idx = int'(msg_bits[8:3]);
        md5_block[idx] = v;
        msg_bits += 64'd8;
        if (idx == 63)
            md5_compress();
    endtask

    // mark byte, zero fill, then the little-endian bit length
    task automatic md5_close(input logic [7:0] mark, input int extra_bits);
        logic [63:0] total;
        int idx, k;
        total = msg_bits + 64'(extra_bits);
        idx = int'(msg_bits[8:3]);
        md5_block[idx] = mark;
        idx++;
        if (idx > 56) begin
            while (idx < 64) begin
                md5_block[idx] = 8'h00;
                idx++;
            end
            md5_compress();
            idx = 0;
        end
        while (idx < 56) begin
            md5_block[idx] = 8'h00;
            idx++;
        end
        for (k = 0; k < 8; k++)
            md5_block[56 + k] = total[8*k +: 8];
        md5_compress();
    endtask

    task automatic hash_item(input t_in_item it);
        t_out_item word;
        logic [7:0] keep;
        int k;
        if (!it.end_of_message) begin
            if (msg_corrupt)
                return;
            if (it.valid_bits == FULL_BITS)
                md5_absorb(it.data_byte);
            else
                msg_corrupt = 1'b1;
            return;
        end
        if (it.valid_bits > FULL_BITS)
            msg_corrupt = 1'b1;
        if (!msg_corrupt) begin
            if (it.valid_bits == FULL_BITS) begin
                md5_absorb(it.data_byte);
                md5_close(MARK_BYTE, 0);
            end else begin
                keep = 8'(16'hff00 >> it.valid_bits);
                md5_close((it.data_byte & keep) | (MARK_BYTE >> it.valid_bits),
                          int'(it.valid_bits));
            end
        end
        for (k = 0; k < 4; k++) begin
            word.digest_word = msg_corrupt ? 32'h0 : md5_chain[k];
            word.word_index  = 2'(k);
            word.last_word   = (2'(k) == LAST_INDEX);
            word.error       = msg_corrupt;
            digest_due.push_back(word);
        end
        md5_restart();
    endtask

    task automatic add_item(input logic [7:0] data, input logic [3:0] bits, input bit eom,
                            input bit hold);
        t_feed f;
        f.item.data_byte      = data;
        f.item.valid_bits     = bits;
        f.item.end_of_message = eom;
        f.wait_digests        = hold;
        feed.push_back(f);
    endtask

    // random message; a few get a short or oversized byte partway through
    task automatic queue_message(input int len, input bit hold);
        int broken_at, bits, j, pick;
        broken_at = (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
        for (j = 0; j < len; j++) begin
            if (j == broken_at) begin
                bits = $urandom_range(0, 14);
                if (bits >= 8)
                    bits++;
            end else if (broken_at >= 0 && j > broken_at) begin
                bits = $urandom_range(0, 15);
            end else begin
                bits = 8;
            end
            add_item(8'($urandom), 4'(bits), 1'b0, hold && j == 0);
        end
        pick = $urandom_range(0, 19);
        if (pick < 10)
            bits = 8;
        else if (pick < 18)
            bits = $urandom_range(0, 7);
        else
            bits = $urandom_range(9, 15);
        add_item(8'($urandom), 4'(bits), 1'b1, hold && len == 0);
    endtask

    initial begin : stimulus
        int len, room;
        bit hold;
        int boundary_len [8];
        boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
        md5_restart();
        // empty message, one full byte, two all-ones bytes
        add_item(8'hff, 4'd0, 1'b1, 1'b0);
        add_item(8'h00, 4'd8, 1'b1, 1'b0);
        add_item(8'hff, 4'd8, 1'b0, 1'b0);
        add_item(8'hff, 4'd8, 1'b1, 1'b0);
        // partial final bytes
        add_item(8'h61, 4'd8, 1'b0, 1'b0);
        add_item(8'hff, 4'd1, 1'b1, 1'b0);
        add_item(8'hff, 4'd7, 1'b1, 1'b0);
        add_item(8'ha5, 4'd3, 1'b1, 1'b0);
        // short byte mid message, later items ignored
        add_item(8'h12, 4'd5, 1'b0, 1'b0);
        add_item(8'h34, 4'd8, 1'b0, 1'b0);
        add_item(8'h56, 4'd2, 1'b0, 1'b0);
        add_item(8'h78, 4'd8, 1'b1, 1'b0);
        // oversized bit counts, mid message and on the final item
        add_item(8'hff, 4'd15, 1'b0, 1'b0);
        add_item(8'h00, 4'd0, 1'b1, 1'b0);
        add_item(8'h00, 4'd9, 1'b1, 1'b0);
        add_item(8'h5a, 4'd8, 1'b0, 1'b0);
        add_item(8'h3c, 4'd12, 1'b1, 1'b0);
        // clean message right after an error
        add_item(8'h80, 4'd8, 1'b0, 1'b0);
        add_item(8'h01, 4'd4, 1'b1, 1'b0);

        hold = 1'b1;
        while (feed.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6:          len = boundary_len[$urandom_range(0, 7)];
                7:             len = $urandom_range(13, 40);
                8:             len = $urandom_range(0, 2);
                default:       len = $urandom_range(0, 70);
            endcase
            // keep the total item count on target
            room = RANDOM_ITEMS - feed.size() - 1;
            if (len > room)
                len = room;
            queue_message(len, hold);
            hold = ($urandom_range(0, 11) == 0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (feed.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (digest_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // byte driver; predicts on every accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                hash_item(i_in_item);
            tail_phase <= (feed.size() < TAIL_ITEMS);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                    i_in_item  <= IN_W'($urandom);
                end else if (feed.size() > 0 &&
                             !(feed[0].wait_digests && digest_due.size() != 0)) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= feed[0].item;
                    void'(feed.pop_front());
                    if (in_run > 0) begin
                        in_run--;
                    end else if (!tail_phase) begin
                        in_gap = $urandom_range(1, 17);
                        in_run = burst_free_span();
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // digest word checker and stall generator
    always @(posedge i_clk) begin : out_side
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (digest_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected digest item %h", o_out_item));
                end else begin
                    want = digest_due.pop_front();
                    if (o_out_item.digest_word !== want.digest_word)
                        flag_mismatch($sformatf("digest_word got %h want %h",
                                                o_out_item.digest_word, want.digest_word));
                    if (o_out_item.word_index !== want.word_index)
                        flag_mismatch($sformatf("word_index got %0d want %0d",
                                                o_out_item.word_index, want.word_index));
                    if (o_out_item.last_word !== want.last_word)
                        flag_mismatch($sformatf("last_word got %b want %b",
                                                o_out_item.last_word, want.last_word));
                    if (o_out_item.error !== want.error)
                        flag_mismatch($sformatf("error got %b want %b",
                                                o_out_item.error, want.error));
                end
            end
            if (out_gap > 0 && !tail_phase) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (out_run > 0) begin
                    out_run--;
                end else if (!tail_phase) begin
                    out_gap = $urandom_range(1, 17);
                    out_run = burst_free_span();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
